>>> hw/rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, ignored while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Unconditional same-cycle implication, checked during reset too.
`define ASSERT_ALWAYS(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/rlfc_pkg.sv
package rlfc_pkg;

    // Levels and steps, in percent
    localparam logic [6:0] FULL_LEVEL  = 7'd100;
    localparam logic [6:0] STEP_LEVEL  = 7'd10;
    localparam logic [6:0] STEP_FLOOR  = 7'd20;
    localparam logic [6:0] ZERO_LEVEL  = 7'd0;

    // Threshold reset values (percent light, whole degrees)
    localparam logic [6:0] LIGHT_THR_RST = 7'd35;
    localparam logic [6:0] TEMP_THR_RST  = 7'd26;

    // Threshold command ranges
    localparam logic [7:0] LIGHT_CMD_LO = 8'd15;
    localparam logic [7:0] LIGHT_CMD_HI = 8'd115;
    localparam logic [7:0] TEMP_CMD_LO  = 8'd116;
    localparam logic [7:0] TEMP_CMD_HI  = 8'd216;

    // Action command codes
    localparam logic [7:0] CMD_LAMP_FULL   = 8'd1;
    localparam logic [7:0] CMD_LAMP_OFF    = 8'd2;
    localparam logic [7:0] CMD_LAMP_UP     = 8'd3;
    localparam logic [7:0] CMD_LAMP_DOWN   = 8'd4;
    localparam logic [7:0] CMD_FAN_FULL    = 8'd5;
    localparam logic [7:0] CMD_FAN_OFF     = 8'd6;
    localparam logic [7:0] CMD_FAN_UP      = 8'd7;
    localparam logic [7:0] CMD_FAN_DOWN    = 8'd8;
    localparam logic [7:0] CMD_FAN_FWD     = 8'd9;
    localparam logic [7:0] CMD_FAN_REV     = 8'd10;
    localparam logic [7:0] CMD_LIGHT_AUTO  = 8'd11;
    localparam logic [7:0] CMD_LIGHT_MAN   = 8'd12;
    localparam logic [7:0] CMD_TEMP_AUTO   = 8'd13;
    localparam logic [7:0] CMD_TEMP_MAN    = 8'd14;

    // One control pass as received
    typedef struct packed {
        logic [7:0]         light_sample;
        logic signed [11:0] temperature_sample;
        logic               command_valid;
        logic [7:0]         command_code;
    } t_item;

    // One result beat
    typedef struct packed {
        logic [6:0]        led_level;
        logic signed [7:0] motor_drive;
        logic              light_auto_on;
        logic              temp_auto_on;
    } t_result;

    // Step up by ten, capped at full
    function automatic logic [6:0] step_up(input logic [6:0] v);
        logic [7:0] sum;
        sum = {1'b0, v} + {1'b0, STEP_LEVEL};
        return (sum > {1'b0, FULL_LEVEL}) ? FULL_LEVEL : sum[6:0];
    endfunction

    // Step down by ten, floor at ten, zero stays zero
    function automatic logic [6:0] step_down(input logic [6:0] v);
        logic [6:0] res;
        if (v == ZERO_LEVEL) begin
            res = ZERO_LEVEL;
        end else if (v < STEP_FLOOR) begin
            res = STEP_LEVEL;
        end else begin
            res = v - STEP_LEVEL;
        end
        return res;
    endfunction

    // Fan level with direction applied
    function automatic logic signed [7:0] signed_fan(input logic [6:0] level,
                                                     input logic       reverse);
        logic signed [7:0] mag;
        mag = $signed({1'b0, level});
        return reverse ? -mag : mag;
    endfunction

endpackage

>>> hw/rtl/remote_light_fan_controller.sv
// Remote light and fan controller.
// Input channel: one beat per control pass, carrying a light sample, a
// temperature sample in signed sixteenths of a degree and an optional
// command byte (i_command_valid). A beat is taken when i_in_valid is high
// and o_in_stall is low.
// Output channel: one beat per input beat, in order, with the LED level,
// the signed fan drive and both automatic-mode flags as they stand after
// that pass. A beat is delivered when o_out_valid is high and i_out_stall
// is low.
// An accepted beat's result shows after the input register and the core
// state registers. Throughput: one beat per cycle unless stalled; the
// input register, one pass of decode and bang-bang logic and the state
// registers set it. While the receiver stalls, the result holds and the
// input register keeps one more beat, after which o_in_stall rises.
// Reset (synchronous, active low): both channels go empty, the LED and fan
// go to zero, forward direction, automatic modes off, light threshold 35
// and temperature threshold 26 degrees.
module remote_light_fan_controller (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [7:0]        i_light_sample,
    input  logic signed [11:0] i_temperature_sample,
    input  logic              i_command_valid,
    input  logic [7:0]        i_command_code,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [6:0]        o_led_level,
    output logic signed [7:0] o_motor_drive,
    output logic              o_light_auto_on,
    output logic              o_temp_auto_on
);
    import rlfc_pkg::*;

    t_item   in_item;
    t_item   q_item;
    t_result result;
    logic    q_valid;
    logic    adv;
    logic    fire;
    logic    r_out_valid;

    assign in_item.light_sample       = i_light_sample;
    assign in_item.temperature_sample = i_temperature_sample;
    assign in_item.command_valid      = i_command_valid;
    assign in_item.command_code       = i_command_code;

    // Result slot frees when empty or being taken
    assign adv  = !r_out_valid || !i_out_stall;
    assign fire = q_valid && adv;

    rlfc_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_item  (in_item),
        .i_take  (adv),
        .o_stall (o_in_stall),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    rlfc_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (q_item),
        .o_result (result)
    );

    // Track the result beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= q_valid;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_led_level     = result.led_level;
    assign o_motor_drive   = result.motor_drive;
    assign o_light_auto_on = result.light_auto_on;
    assign o_temp_auto_on  = result.temp_auto_on;

endmodule

>>> hw/rtl/rlfc_in_stage.sv
module rlfc_in_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  rlfc_pkg::t_item i_item,
    input  logic           i_take,
    output logic           o_stall,
    output logic           o_valid,
    output rlfc_pkg::t_item o_item
);
    import rlfc_pkg::*;

    logic  r_valid;
    t_item r_item;
    logic  load;

    // Hold the beat while the core cannot take it
    assign o_stall = r_valid && !i_take;
    assign load    = !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= i_valid;
        end
    end

    // Capture payload on accept
    always_ff @(posedge i_clk) begin
        if (load && i_valid) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

>>> hw/rtl/rlfc_core.sv
module rlfc_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  rlfc_pkg::t_item  i_item,
    output rlfc_pkg::t_result o_result
);
    import rlfc_pkg::*;

    logic [6:0]        r_lamp_level,   n_lamp_level;
    logic [6:0]        r_fan_level,    n_fan_level;
    logic              r_fan_reverse,  n_fan_reverse;
    logic signed [7:0] r_drive_value,  n_drive_value;
    logic              r_light_auto,   n_light_auto;
    logic              r_temp_auto,    n_temp_auto;
    logic [6:0]        r_light_thr,    n_light_thr;
    logic [6:0]        r_temp_thr,     n_temp_thr;
    logic [7:0]        cmd_off_light;
    logic [7:0]        cmd_off_temp;
    logic signed [11:0] temp_limit;

    assign cmd_off_light = i_item.command_code - LIGHT_CMD_LO;
    assign cmd_off_temp  = i_item.command_code - TEMP_CMD_LO;

    // Decode the command, then apply the automatic modes
    always_comb begin
        n_lamp_level  = r_lamp_level;
        n_fan_level   = r_fan_level;
        n_fan_reverse = r_fan_reverse;
        n_drive_value = r_drive_value;
        n_light_auto  = r_light_auto;
        n_temp_auto   = r_temp_auto;
        n_light_thr   = r_light_thr;
        n_temp_thr    = r_temp_thr;
        temp_limit    = 12'sd0;

        if (i_item.command_valid) begin
            case (i_item.command_code)
                CMD_LAMP_FULL: n_lamp_level = FULL_LEVEL;
                CMD_LAMP_OFF:  n_lamp_level = ZERO_LEVEL;
                CMD_LAMP_UP:   n_lamp_level = step_up(r_lamp_level);
                CMD_LAMP_DOWN: n_lamp_level = step_down(r_lamp_level);
                CMD_FAN_FULL: begin
                    n_fan_level   = FULL_LEVEL;
                    n_drive_value = $signed({1'b0, FULL_LEVEL});
                end
                CMD_FAN_OFF: begin
                    n_fan_level   = ZERO_LEVEL;
                    n_drive_value = 8'sd0;
                end
                CMD_FAN_UP: begin
                    n_fan_level   = step_up(r_fan_level);
                    n_drive_value = signed_fan(n_fan_level, r_fan_reverse);
                end
                CMD_FAN_DOWN: begin
                    n_fan_level   = step_down(r_fan_level);
                    n_drive_value = signed_fan(n_fan_level, r_fan_reverse);
                end
                CMD_FAN_FWD: begin
                    n_fan_reverse = 1'b0;
                    n_drive_value = signed_fan(r_fan_level, 1'b0);
                end
                CMD_FAN_REV: begin
                    n_fan_reverse = 1'b1;
                    n_drive_value = signed_fan(r_fan_level, 1'b1);
                end
                CMD_LIGHT_AUTO: n_light_auto = 1'b1;
                CMD_LIGHT_MAN: begin
                    n_light_auto = 1'b0;
                    n_lamp_level = ZERO_LEVEL;
                end
                CMD_TEMP_AUTO: n_temp_auto = 1'b1;
                CMD_TEMP_MAN: begin
                    n_temp_auto   = 1'b0;
                    n_fan_level   = ZERO_LEVEL;
                    n_drive_value = 8'sd0;
                end
                default: begin
                    if (i_item.command_code >= LIGHT_CMD_LO &&
                        i_item.command_code <= LIGHT_CMD_HI) begin
                        n_light_thr = cmd_off_light[6:0];
                    end else if (i_item.command_code >= TEMP_CMD_LO &&
                                 i_item.command_code <= TEMP_CMD_HI) begin
                        n_temp_thr = cmd_off_temp[6:0];
                    end
                end
            endcase
        end

        // Bang-bang light control
        if (n_light_auto) begin
            n_lamp_level = ({1'b0, i_item.light_sample} < {2'b00, n_light_thr})
                           ? FULL_LEVEL : ZERO_LEVEL;
        end

        // Bang-bang fan control, threshold scaled to sixteenths
        temp_limit = $signed({1'b0, n_temp_thr, 4'b0000});
        if (n_temp_auto) begin
            if (i_item.temperature_sample > temp_limit) begin
                n_fan_level   = FULL_LEVEL;
                n_drive_value = $signed({1'b0, FULL_LEVEL});
            end else begin
                n_fan_level   = ZERO_LEVEL;
                n_drive_value = 8'sd0;
            end
        end
    end

    // Advance state once per passing beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lamp_level  <= ZERO_LEVEL;
            r_fan_level   <= ZERO_LEVEL;
            r_fan_reverse <= 1'b0;
            r_drive_value <= 8'sd0;
            r_light_auto  <= 1'b0;
            r_temp_auto   <= 1'b0;
            r_light_thr   <= LIGHT_THR_RST;
            r_temp_thr    <= TEMP_THR_RST;
        end else if (i_fire) begin
            r_lamp_level  <= n_lamp_level;
            r_fan_level   <= n_fan_level;
            r_fan_reverse <= n_fan_reverse;
            r_drive_value <= n_drive_value;
            r_light_auto  <= n_light_auto;
            r_temp_auto   <= n_temp_auto;
            r_light_thr   <= n_light_thr;
            r_temp_thr    <= n_temp_thr;
        end
    end

    // The updated state registers are the result register
    assign o_result.led_level     = r_lamp_level;
    assign o_result.motor_drive   = r_drive_value;
    assign o_result.light_auto_on = r_light_auto;
    assign o_result.temp_auto_on  = r_temp_auto;

endmodule

>>> hw/rtl/rlfc_checker.sv
`include "assert_macros.svh"

module rlfc_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input logic [7:0]        i_light_sample,
    input logic signed [11:0] i_temperature_sample,
    input logic              i_command_valid,
    input logic [7:0]        i_command_code,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic [6:0]        o_led_level,
    input logic signed [7:0] o_motor_drive,
    input logic              o_light_auto_on,
    input logic              o_temp_auto_on
);

    // Stalled result beat holds
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_led_level) && $stable(o_motor_drive) && $stable(o_light_auto_on) && $stable(o_temp_auto_on), "result beat changed while stalled")

    // Automatic light leaves the LED fully on or off
    `ASSERT_IMPL(a_light_auto, i_clk, i_rst_n, o_out_valid && o_light_auto_on, o_led_level == 7'd0 || o_led_level == 7'd100, "LED level off the rails under automatic light")

    // Automatic temperature leaves the fan at zero or full forward
    `ASSERT_IMPL(a_temp_auto, i_clk, i_rst_n, o_out_valid && o_temp_auto_on, o_motor_drive == 8'sd0 || o_motor_drive == 8'sd100, "fan drive off the rails under automatic temperature")

    // An accept with an empty result slot is offered as a result once it passes the core
    `ASSERT_NEXT(a_latency, i_clk, i_rst_n, i_in_valid && !o_in_stall && !o_out_valid, ##1 o_out_valid, "accepted beat gave no result")

    // Right after a reset edge no result is offered
    `ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n, ##1 !o_out_valid, "result valid after reset")

endmodule

bind remote_light_fan_controller rlfc_checker u_rlfc_checker (.*);

>>> tb/sv/remote_light_fan_controller_checker.sv
module remote_light_fan_controller_checker
    import rlfc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic [7:0]         i_light_sample,
    input  logic signed [11:0] i_temperature_sample,
    input  logic               i_command_valid,
    input  logic [7:0]         i_command_code,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic [6:0]         i_led_level,
    input  logic signed [7:0]  i_motor_drive,
    input  logic               i_light_auto_on,
    input  logic               i_temp_auto_on,
    output int                 o_error_count,
    output int                 o_pending
);

    localparam logic signed [7:0] DRIVE_FULL = 8'sd100;
    localparam logic signed [7:0] DRIVE_STOP = 8'sd0;
    localparam int                MAX_PRINTED = 100;

    // Shadow copy of the controller state
    logic [6:0]        lamp;
    logic [6:0]        fan;
    logic              fan_rev;
    logic signed [7:0] drive;
    logic              light_auto;
    logic              temp_auto;
    logic [6:0]        light_thr;
    logic [6:0]        temp_thr;

    // Status beats still owed by the block, oldest first
    t_result expected_status[$];

    // Print one line for a failed check, for the first 100 only, and count it
    task automatic report_error(input string what);
        if (o_error_count < MAX_PRINTED) begin
            $display("[%0t] status check: %s", $time, what);
        end
        o_error_count = o_error_count + 1;
    endtask

    // Step up by ten, saturate at full
    function automatic logic [6:0] raise_level(input logic [6:0] level);
        return (level > FULL_LEVEL - STEP_LEVEL) ? FULL_LEVEL : level + STEP_LEVEL;
    endfunction

    // Step down by ten, hold at ten, keep zero at zero
    function automatic logic [6:0] lower_level(input logic [6:0] level);
        logic [6:0] res;
        if (level == 7'd0) begin
            res = 7'd0;
        end else if (level < 2 * STEP_LEVEL) begin
            res = STEP_LEVEL;
        end else begin
            res = level - STEP_LEVEL;
        end
        return res;
    endfunction

    // Current fan level as a signed drive, negative in reverse
    function automatic logic signed [7:0] fan_drive();
        logic signed [7:0] mag;
        mag = $signed({1'b0, fan});
        return fan_rev ? DRIVE_STOP - mag : mag;
    endfunction

    // Apply one control pass to the shadow state and return the status after it
    function automatic t_result run_control_pass(input logic [7:0]         light,
                                                 input logic signed [11:0] temp,
                                                 input logic               cv,
                                                 input logic [7:0]         code);
        t_result    res;
        logic [7:0] offset;
        if (cv) begin
            case (code)
                CMD_LAMP_FULL:  lamp = FULL_LEVEL;
                CMD_LAMP_OFF:   lamp = 7'd0;
                CMD_LAMP_UP:    lamp = raise_level(lamp);
                CMD_LAMP_DOWN:  lamp = lower_level(lamp);
                CMD_FAN_FULL: begin
                    fan   = FULL_LEVEL;
                    drive = DRIVE_FULL;
                end
                CMD_FAN_OFF: begin
                    fan   = 7'd0;
                    drive = DRIVE_STOP;
                end
                CMD_FAN_UP: begin
                    fan   = raise_level(fan);
                    drive = fan_drive();
                end
                CMD_FAN_DOWN: begin
                    fan   = lower_level(fan);
                    drive = fan_drive();
                end
                CMD_FAN_FWD: begin
                    fan_rev = 1'b0;
                    drive   = fan_drive();
                end
                CMD_FAN_REV: begin
                    fan_rev = 1'b1;
                    drive   = fan_drive();
                end
                CMD_LIGHT_AUTO: light_auto = 1'b1;
                CMD_LIGHT_MAN: begin
                    light_auto = 1'b0;
                    lamp       = 7'd0;
                end
                CMD_TEMP_AUTO:  temp_auto = 1'b1;
                CMD_TEMP_MAN: begin
                    temp_auto = 1'b0;
                    fan       = 7'd0;
                    drive     = DRIVE_STOP;
                end
                default: begin
                    // Threshold ranges; anything else changes nothing
                    if (code >= LIGHT_CMD_LO && code <= LIGHT_CMD_HI) begin
                        offset    = code - LIGHT_CMD_LO;
                        light_thr = offset[6:0];
                    end else if (code >= TEMP_CMD_LO && code <= TEMP_CMD_HI) begin
                        offset   = code - TEMP_CMD_LO;
                        temp_thr = offset[6:0];
                    end
                end
            endcase
        end

        // Bang-bang control after the command
        if (light_auto) begin
            lamp = (light < {1'b0, light_thr}) ? FULL_LEVEL : 7'd0;
        end
        if (temp_auto) begin
            if (int'(temp) > 16 * int'(temp_thr)) begin
                fan   = FULL_LEVEL;
                drive = DRIVE_FULL;
            end else begin
                fan   = 7'd0;
                drive = DRIVE_STOP;
            end
        end

        res.led_level     = lamp;
        res.motor_drive   = drive;
        res.light_auto_on = light_auto;
        res.temp_auto_on  = temp_auto;
        return res;
    endfunction

    // Compare delivered beats, then predict for accepted beats
    always @(posedge i_clk) begin : watch
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            lamp       = 7'd0;
            fan        = 7'd0;
            fan_rev    = 1'b0;
            drive      = DRIVE_STOP;
            light_auto = 1'b0;
            temp_auto  = 1'b0;
            light_thr  = LIGHT_THR_RST;
            temp_thr   = TEMP_THR_RST;
            expected_status.delete();
            o_error_count = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                got.led_level     = i_led_level;
                got.motor_drive   = i_motor_drive;
                got.light_auto_on = i_light_auto_on;
                got.temp_auto_on  = i_temp_auto_on;
                if (expected_status.size() == 0) begin
                    report_error("status beat delivered with nothing expected");
                end else begin
                    want = expected_status.pop_front();
                    if (got.led_level !== want.led_level) begin
                        report_error($sformatf("led_level got %0d expected %0d",
                                               got.led_level, want.led_level));
                    end
                    if (got.motor_drive !== want.motor_drive) begin
                        report_error($sformatf("motor_drive got %0d expected %0d",
                                               got.motor_drive, want.motor_drive));
                    end
                    if (got.light_auto_on !== want.light_auto_on) begin
                        report_error($sformatf("light_auto_on got %b expected %b",
                                               got.light_auto_on, want.light_auto_on));
                    end
                    if (got.temp_auto_on !== want.temp_auto_on) begin
                        report_error($sformatf("temp_auto_on got %b expected %b",
                                               got.temp_auto_on, want.temp_auto_on));
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                expected_status.push_back(run_control_pass(i_light_sample,
                                                           i_temperature_sample,
                                                           i_command_valid,
                                                           i_command_code));
            end
        end
        o_pending = expected_status.size();
    end

endmodule

>>> tb/sv/remote_light_fan_controller_tb.sv
module remote_light_fan_controller_tb;
    import rlfc_pkg::*;

    localparam logic [7:0] NO_OP_CMD    = 8'd0;
    localparam int         RANDOM_PASSES = 725;
    localparam int         HOLD_AT       = 520;
    localparam int         HOLD_CYCLES   = 60;

    logic               i_clk;
    logic               i_rst_n              = 1'b0;
    logic               i_in_valid           = 1'b0;
    logic [7:0]         i_light_sample       = '0;
    logic signed [11:0] i_temperature_sample = '0;
    logic               i_command_valid      = 1'b0;
    logic [7:0]         i_command_code       = '0;
    logic               i_out_stall          = 1'b0;
    logic               o_in_stall;
    logic               o_out_valid;
    logic [6:0]         o_led_level;
    logic signed [7:0]  o_motor_drive;
    logic               o_light_auto_on;
    logic               o_temp_auto_on;

    int error_count;
    int pending_count;
    int passes_sent   = 0;
    bit calm          = 1'b0;
    int light_thr_set = 35;
    int temp_thr_set  = 26;

    remote_light_fan_controller uut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_in_valid           (i_in_valid),
        .o_in_stall           (o_in_stall),
        .i_light_sample       (i_light_sample),
        .i_temperature_sample (i_temperature_sample),
        .i_command_valid      (i_command_valid),
        .i_command_code       (i_command_code),
        .o_out_valid          (o_out_valid),
        .i_out_stall          (i_out_stall),
        .o_led_level          (o_led_level),
        .o_motor_drive        (o_motor_drive),
        .o_light_auto_on      (o_light_auto_on),
        .o_temp_auto_on       (o_temp_auto_on)
    );

    remote_light_fan_controller_checker status_check (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_in_valid           (i_in_valid),
        .i_in_stall           (o_in_stall),
        .i_light_sample       (i_light_sample),
        .i_temperature_sample (i_temperature_sample),
        .i_command_valid      (i_command_valid),
        .i_command_code       (i_command_code),
        .i_out_valid          (o_out_valid),
        .i_out_stall          (i_out_stall),
        .i_led_level          (o_led_level),
        .i_motor_drive        (o_motor_drive),
        .i_light_auto_on      (o_light_auto_on),
        .i_temp_auto_on       (o_temp_auto_on),
        .o_error_count        (error_count),
        .o_pending            (pending_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Drop out about 38 times in a hundred, never while calm
    function automatic bit idle_now();
        return !calm && ($urandom_range(99) < 38);
    endfunction

    // Offer one control pass and hold it until the block takes the beat
    task automatic send_pass(input logic [7:0]         light,
                             input logic signed [11:0] temp,
                             input logic               cv,
                             input logic [7:0]         code);
        while (idle_now()) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid           <= 1'b1;
        i_light_sample       <= light;
        i_temperature_sample <= temp;
        i_command_valid      <= cv;
        i_command_code       <= code;
        do @(posedge i_clk); while (o_in_stall);
        passes_sent++;
        // Track thresholds so random samples can land near them
        if (cv && code >= LIGHT_CMD_LO && code <= LIGHT_CMD_HI) begin
            light_thr_set = int'(code) - int'(LIGHT_CMD_LO);
        end else if (cv && code >= TEMP_CMD_LO && code <= TEMP_CMD_HI) begin
            temp_thr_set = int'(code) - int'(TEMP_CMD_LO);
        end
    endtask

    // Receiver: random stalls, plus one long hold-off to back the block up
    initial begin : receiver
        int hold_left;
        bit held;
        hold_left = 0;
        held      = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (!held && passes_sent >= HOLD_AT) begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= idle_now();
            end
        end
    end

    initial begin : stimulus
        int         r;
        int         lv;
        int         tv;
        logic       cv;
        logic [7:0] code;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Step limits: zero stays zero, ten holds, full caps
        send_pass(8'd0, 12'sd0, 1'b1, CMD_LAMP_DOWN);
        send_pass(8'd255, 12'sd0, 1'b1, CMD_FAN_DOWN);
        send_pass(8'd17, 12'sd100, 1'b1, CMD_LAMP_UP);
        send_pass(8'd17, 12'sd100, 1'b1, CMD_LAMP_DOWN);
        send_pass(8'd128, -12'sd1, 1'b1, CMD_LAMP_FULL);
        send_pass(8'd128, -12'sd1, 1'b1, CMD_LAMP_UP);
        send_pass(8'd64, 12'sd2047, 1'b1, CMD_LAMP_OFF);
        // Fan direction and signed drive
        send_pass(8'd1, 12'sd0, 1'b1, CMD_FAN_REV);
        send_pass(8'd2, 12'sd0, 1'b1, CMD_FAN_UP);
        send_pass(8'd4, 12'sd0, 1'b1, CMD_FAN_DOWN);
        send_pass(8'd8, 12'sd0, 1'b1, CMD_FAN_FULL);
        send_pass(8'd16, 12'sd0, 1'b1, CMD_FAN_FWD);
        send_pass(8'd32, 12'sd0, 1'b1, CMD_FAN_DOWN);
        send_pass(8'd64, 12'sd0, 1'b1, CMD_FAN_OFF);
        // Temperature control around the top threshold, then the bottom one
        send_pass(8'd0, 12'sd2000, 1'b1, TEMP_CMD_HI);
        send_pass(8'd0, 12'sd2000, 1'b1, CMD_TEMP_AUTO);
        send_pass(8'd0, 12'sd1600, 1'b0, CMD_FAN_FULL);
        send_pass(8'd0, 12'sd1601, 1'b0, NO_OP_CMD);
        send_pass(8'd0, -12'sd880, 1'b1, TEMP_CMD_LO);
        send_pass(8'd0, 12'sd1, 1'b1, CMD_TEMP_MAN);
        // Light control at the top threshold, then the bottom one
        send_pass(8'd99, 12'sd0, 1'b1, LIGHT_CMD_HI);
        send_pass(8'd99, 12'sd0, 1'b1, CMD_LIGHT_AUTO);
        send_pass(8'd255, 12'sd0, 1'b0, CMD_LAMP_FULL);
        send_pass(8'd0, 12'sd0, 1'b1, LIGHT_CMD_LO);
        send_pass(8'd0, 12'sd0, 1'b1, CMD_LIGHT_MAN);
        // Unused codes
        send_pass(8'd85, 12'sd0, 1'b1, NO_OP_CMD);
        send_pass(8'd170, -12'sd2, 1'b1, 8'd255);

        // Random passes, one calm stretch in the middle
        for (int n = 0; n < RANDOM_PASSES; n++) begin
            calm = (n >= 250 && n < 400);

            if ($urandom_range(1)) begin
                lv = light_thr_set - 1 + int'($urandom_range(1));
                if (lv < 0) lv = 0;
            end else begin
                lv = $urandom_range(255);
            end

            r = $urandom_range(99);
            if (r < 45) begin
                tv = 16 * temp_thr_set - 1 + int'($urandom_range(2));
            end else if (r < 52) begin
                tv = $urandom_range(1) ? 2000 : -880;
            end else begin
                tv = int'($urandom_range(2880)) - 880;
            end

            cv = ($urandom_range(99) < 65);
            r  = $urandom_range(99);
            if (!cv) begin
                code = 8'($urandom_range(255));
            end else if (r < 55) begin
                code = 8'($urandom_range(CMD_TEMP_MAN, CMD_LAMP_FULL));
            end else if (r < 75) begin
                code = 8'($urandom_range(LIGHT_CMD_HI, LIGHT_CMD_LO));
            end else if (r < 95) begin
                code = 8'($urandom_range(TEMP_CMD_HI, TEMP_CMD_LO));
            end else if ($urandom_range(1)) begin
                code = NO_OP_CMD;
            end else begin
                code = 8'($urandom_range(255, TEMP_CMD_HI + 1));
            end

            send_pass(lv[7:0], tv[11:0], cv, code);
        end
        calm = 1'b0;
        i_in_valid <= 1'b0;

        // Drain what is owed, then let the pipeline settle
        @(posedge i_clk);
        wait (pending_count == 0);
        repeat (10) @(posedge i_clk);
        if (error_count == 0) begin
            $display("remote_light_fan_controller: match");
        end else begin
            $display("remote_light_fan_controller: mismatch");
        end
        $finish;
    end

    initial begin : watchdog
        #200000;
        $display("remote_light_fan_controller: mismatch");
        $finish;
    end

endmodule
